/* rtl/core/uad_pkg.sv */
// uad_pkg: shared types, constants and tables of the url autolink detector
// no dependencies; imported by uad_step, url_autolink_detector and uad_checker
package uad_pkg;

  localparam int unsigned LEN_WIDTH_DEF = 16;
  localparam int unsigned NUM_SCHEMES   = 4;
  localparam int unsigned PFX_MAX_LEN   = 8;
  localparam int unsigned POS_W         = $clog2(PFX_MAX_LEN);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // scheme codes
  localparam logic [1:0] SCH_HTTP   = 2'd0;
  localparam logic [1:0] SCH_HTTPS  = 2'd1;
  localparam logic [1:0] SCH_FTP    = 2'd2;
  localparam logic [1:0] SCH_MAILTO = 2'd3;

  // shortest prefix; any match reports at least this many link bytes
  localparam logic [15:0] MIN_LINK_LEN = 16'd6;

  // prefix text, one byte per position, unused positions zero
  localparam logic [7:0] PFX_CHAR [NUM_SCHEMES][PFX_MAX_LEN] = '{
    '{"h", "t", "t", "p", ":", "/", "/", 8'h00},
    '{"h", "t", "t", "p", "s", ":", "/", "/"},
    '{"f", "t", "p", ":", "/", "/", 8'h00, 8'h00},
    '{"m", "a", "i", "l", "t", "o", ":", 8'h00}
  };

  localparam logic [3:0] PFX_LEN [NUM_SCHEMES] = '{4'd7, 4'd8, 4'd6, 4'd7};

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_TAIL
  } phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       begin_req;
    logic       at_text_start;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic        matched;
    logic        blank_len;
    logic [1:0]  scheme_index;
    logic [15:0] link_len;
  } out_word_t;

  // scan state apart from the link counter, whose width is a parameter
  typedef struct packed {
    phase_e           phase;
    logic [3:0]       alive;
    logic [POS_W-1:0] pos;
    logic             lead_blank;
    logic [7:0]       prev_char;
    logic [1:0]       scheme;
  } scan_state_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c == ",") || (c == ".") || (c == "?") || (c == "!") ||
           (c == ":") || (c == ";") || (c == "'");
  endfunction

endpackage

/* rtl/core/uad_step.sv */
// uad_step: next-state and result logic for one text byte
// depends on uad_pkg
module uad_step #(
  parameter int unsigned LEN_WIDTH = uad_pkg::LEN_WIDTH_DEF
) (
  input  uad_pkg::in_word_t    word_i,
  input  uad_pkg::scan_state_t st_i,
  input  logic [LEN_WIDTH-1:0] cnt_i,
  output uad_pkg::scan_state_t st_o,
  output logic [LEN_WIDTH-1:0] cnt_o,
  output logic                 emit_o,
  output uad_pkg::out_word_t   res_o
);
  import uad_pkg::*;

  localparam logic [LEN_WIDTH-1:0] CntMax = '1;
  localparam int unsigned RepW = (LEN_WIDTH > 16) ? LEN_WIDTH : 16;

  scan_state_t          st_e;
  logic [LEN_WIDTH-1:0] cnt_e;
  logic [LEN_WIDTH-1:0] cnt_inc;
  logic [3:0]           alive_n;
  logic                 done;
  logic [1:0]           done_sch;
  logic                 term;
  logic [LEN_WIDTH-1:0] fcnt;
  logic [7:0]           fprev;
  logic                 flen_ok;
  logic [LEN_WIDTH-1:0] flen;
  logic [RepW-1:0]      flen_ext;
  out_word_t            fin_res;

  // effective state: a begin byte restarts the attempt
  always_comb begin
    st_e  = st_i;
    cnt_e = cnt_i;
    if (word_i.begin_req) begin
      st_e.phase      = PH_PREFIX;
      st_e.alive      = 4'hF;
      st_e.pos        = '0;
      st_e.lead_blank = is_blank(word_i.ch);
      st_e.prev_char  = 8'h00;
      st_e.scheme     = SCH_HTTP;
      cnt_e           = '0;
    end
  end

  // prefix compare, all schemes side by side
  always_comb begin
    alive_n  = '0;
    done     = 1'b0;
    done_sch = SCH_HTTP;
    for (int j = 0; j < NUM_SCHEMES; j++) begin
      alive_n[j] = st_e.alive[j] && ({1'b0, st_e.pos} < PFX_LEN[j]) &&
                   (word_i.ch == PFX_CHAR[j][st_e.pos]);
    end
    for (int j = NUM_SCHEMES - 1; j >= 0; j--) begin
      if (alive_n[j] && (({1'b0, st_e.pos} + 4'd1) == PFX_LEN[j])) begin
        done     = 1'b1;
        done_sch = 2'(j);
      end
    end
  end

  // tail: counter and end-of-link evaluation
  always_comb begin
    term     = (word_i.ch == CH_QUOTE) || (word_i.ch <= CH_SPACE);
    cnt_inc  = (cnt_e == CntMax) ? cnt_e : cnt_e + LEN_WIDTH'(1);
    fcnt     = term ? cnt_e : cnt_inc;
    fprev    = term ? st_e.prev_char : word_i.ch;
    flen_ok  = fcnt > LEN_WIDTH'(PFX_LEN[st_e.scheme]);
    flen     = fcnt - LEN_WIDTH'((fcnt != CntMax) && is_punct(fprev));
    flen_ext = RepW'(flen);
    fin_res  = '0;
    if (flen_ok) begin
      fin_res.matched      = 1'b1;
      fin_res.blank_len    = st_e.lead_blank;
      fin_res.scheme_index = st_e.scheme;
      fin_res.link_len     = (flen_ext > RepW'(16'hFFFF)) ? 16'hFFFF : flen_ext[15:0];
    end
  end

  always_comb begin
    st_o   = st_e;
    cnt_o  = cnt_e;
    emit_o = 1'b0;
    res_o  = '0;
    if (word_i.begin_req && is_blank(word_i.ch)) begin
      if (word_i.end_of_text) begin
        emit_o     = 1'b1;
        st_o.phase = PH_IDLE;
      end
    end else if (word_i.begin_req && !word_i.at_text_start) begin
      emit_o     = 1'b1;
      st_o.phase = PH_IDLE;
    end else begin
      unique case (st_e.phase)
        PH_PREFIX: begin
          st_o.alive = alive_n;
          if (alive_n == 4'h0) begin
            emit_o     = 1'b1;
            st_o.phase = PH_IDLE;
          end else begin
            if (done) begin
              st_o.scheme    = done_sch;
              st_o.prev_char = word_i.ch;
              st_o.phase     = PH_TAIL;
              cnt_o          = LEN_WIDTH'(PFX_LEN[done_sch]);
            end else begin
              st_o.pos = st_e.pos + POS_W'(1);
            end
            if (word_i.end_of_text) begin
              emit_o     = 1'b1;
              st_o.phase = PH_IDLE;
            end
          end
        end
        PH_TAIL: begin
          if (!term) begin
            cnt_o          = cnt_inc;
            st_o.prev_char = word_i.ch;
          end
          if (term || word_i.end_of_text) begin
            emit_o     = 1'b1;
            res_o      = fin_res;
            st_o.phase = PH_IDLE;
          end
        end
        default: begin
          // idle byte without begin: nothing to do
        end
      endcase
    end
  end

endmodule

/* rtl/core/url_autolink_detector.sv */
// url_autolink_detector: top level of the url autolink recognizer
// depends on uad_pkg and uad_step
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+-----------------------
//  in      | input     | in_valid_i / in_stall_o   | uad_pkg::in_word_t
//  out     | output    | out_valid_o / out_stall_i | uad_pkg::out_word_t
//
// one text byte per cycle while in_stall_o is low; a byte is held in the
// input register and its result, if any, is loaded into the output
// register when that byte is processed, so a result passes both registers
// reset (async, active low) empties both registers and returns the scan to idle
// a stalled result holds the output register; the input register then holds
// its byte and in_stall_o rises until the result is taken
module url_autolink_detector #(
  parameter int unsigned LEN_WIDTH = uad_pkg::LEN_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  uad_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uad_pkg::out_word_t out_word_o
);
  import uad_pkg::*;

  // input register
  logic        in_valid_q;
  in_word_t    in_word_q;

  // output register
  logic        out_valid_q;
  out_word_t   out_word_q;

  // scan state
  scan_state_t          st_q, st_d;
  logic [LEN_WIDTH-1:0] cnt_q, cnt_d;

  logic        emit;
  out_word_t   res;
  logic        out_free;
  logic        proc;
  logic        in_take;

  // output slot is free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  // the buffered byte is consumed only when its result has somewhere to go
  assign proc     = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take  = in_valid_i && !in_stall_o;

  uad_step #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_step (
    .word_i (in_word_q),
    .st_i   (st_q),
    .cnt_i  (cnt_q),
    .st_o   (st_d),
    .cnt_o  (cnt_d),
    .emit_o (emit),
    .res_o  (res)
  );

  // control and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      st_q.phase         <= PH_IDLE;
      st_q.alive         <= '0;
      st_q.pos           <= '0;
      st_q.lead_blank    <= 1'b0;
      st_q.prev_char     <= '0;
      st_q.scheme        <= SCH_HTTP;
      cnt_q              <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        out_valid_q <= emit;
        st_q        <= st_d;
        cnt_q       <= cnt_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
    if (proc && emit) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* rtl/core/uad_checker.sv */
// uad_checker: port-level assertions for url_autolink_detector, bound below
// depends on uad_pkg
module uad_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input uad_pkg::out_word_t out_word_o
);
  import uad_pkg::*;

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result word does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // a fresh result needs a byte taken at the input before it
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a preceding byte");

  // no-match results carry all-zero fields
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.matched |->
      !out_word_o.blank_len && (out_word_o.scheme_index == SCH_HTTP) &&
      (out_word_o.link_len == 16'd0))
    else $error("no-match result with nonzero fields");

  // a match is at least as long as the shortest prefix
  a_match_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.matched |-> out_word_o.link_len >= MIN_LINK_LEN)
    else $error("matched link shorter than any prefix");

endmodule

bind url_autolink_detector uad_checker u_uad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
